// ===== rtl/core/aihc_pkg.sv =====
// Shared types and constants for the inversion height correction block.
// No dependencies; imported by every module of the block.
package aihc_pkg;

  localparam int P_W   = 17;
  localparam int T_W   = 16;
  localparam int RH_W  = 14;
  localparam int MC_W  = 8;
  localparam int CFG_W = 17;
  localparam int IDX_W = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RH_W-1:0] RH_LIMIT_RST      = RH_W'(5000);
  localparam logic [P_W-1:0]  P_FLOOR_RST       = P_W'(70000);
  localparam logic [P_W-1:0]  P_CEILING_RST     = P_W'(96000);
  localparam logic [T_W-1:0]  INV_TEMP_RST      = '0;
  localparam logic [MC_W-1:0] INFRARED_CODE_RST = MC_W'(1);
  localparam logic [MC_W-1:0] VISIBLE_CODE_RST  = MC_W'(2);
  localparam logic [P_W-1:0]  BASE_PRESSURE_RST = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_RH_LIMIT      = 3'd0,
    REG_P_FLOOR       = 3'd1,
    REG_P_CEILING     = 3'd2,
    REG_INV_TEMP      = 3'd3,
    REG_INFRARED_CODE = 3'd4,
    REG_VISIBLE_CODE  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [RH_W-1:0]       rh_limit;
    logic [P_W-1:0]        p_floor;
    logic [P_W-1:0]        p_ceiling;
    logic signed [T_W-1:0] min_rise;
    logic [MC_W-1:0]       infrared_code;
    logic [MC_W-1:0]       visible_code;
  } cfg_t;

  typedef struct packed {
    logic [P_W-1:0]  level_pressure;
    logic [T_W-1:0]  level_temp;
    logic [RH_W-1:0] level_rh;
    logic [P_W-1:0]  assigned_p;
    logic            eligible;
    logic            last_level;
  } lvl_t;

endpackage

// ===== rtl/core/aihc_front.sv =====
// Front end: accepts level words and tags each with observation eligibility.
// Depends on aihc_pkg.
module aihc_front
  import aihc_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [P_W-1:0]   level_pressure,
  input  logic [T_W-1:0]   level_temp,
  input  logic [RH_W-1:0]  level_rh,
  input  logic [P_W-1:0]   assigned_p,
  input  logic [MC_W-1:0]  method_code,
  input  logic             apply_obs,
  input  logic             last_level,
  output lvl_t             lvl
);

  logic code_ok;

  assign code_ok = (method_code == cfg.infrared_code) || (method_code == cfg.visible_code);

  always_comb begin
    lvl.level_pressure = level_pressure;
    lvl.level_temp     = level_temp;
    lvl.level_rh       = level_rh;
    lvl.assigned_p     = assigned_p;
    lvl.eligible       = apply_obs && (assigned_p >= cfg.p_floor) && code_ok;
    lvl.last_level     = last_level;
  end

endmodule

// ===== rtl/core/aihc_queue.sv =====
// Short queue of tagged level words between front and back ends.
// Depends on aihc_pkg.
module aihc_queue
  import aihc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  lvl_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output lvl_t head
);

  lvl_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/aihc_back.sv =====
// Back end: inversion scan over level pairs and result register.
// Depends on aihc_pkg.
module aihc_back
  import aihc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  logic            lvl_valid,
  input  lvl_t            lvl,
  output logic            lvl_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [P_W-1:0]  out_new_pressure,
  output logic            out_corrected,
  output logic            out_order_error
);

  logic            have_prev_r, have_prev_nxt;
  logic [P_W-1:0]  prev_p_r, prev_p_nxt;
  logic [T_W-1:0]  prev_t_r, prev_t_nxt;
  logic [RH_W-1:0] prev_rh_r, prev_rh_nxt;
  logic [P_W-1:0]  bottom_p_r, bottom_p_nxt;
  logic            stop_r, stop_nxt;
  logic            inv_r, inv_nxt;
  logic            top_r, top_nxt;
  logic [P_W-1:0]  base_p_r, base_p_nxt;
  logic [T_W-1:0]  base_t_r, base_t_nxt;
  logic [T_W-1:0]  top_t_r, top_t_nxt;

  logic            s_stop, s_inv, s_top;
  logic [P_W-1:0]  s_bottom, s_base_p;
  logic [T_W-1:0]  s_base_t, s_top_t;

  logic            res_valid_r, res_valid_nxt;
  logic [P_W-1:0]  res_p_r, res_p_nxt;
  logic            res_corr_r, res_corr_nxt;
  logic            res_oerr_r, res_oerr_nxt;

  logic signed [T_W+1:0] temp_diff;
  logic                  temp_ok;
  logic                  take;

  assign take    = lvl_valid && (!lvl.last_level || !res_valid_r || out_pop);
  assign lvl_pop = take;

  assign out_empty        = !res_valid_r;
  assign out_new_pressure = res_p_r;
  assign out_corrected    = res_corr_r;
  assign out_order_error  = res_oerr_r;

  always_comb begin
    s_stop   = stop_r;
    s_inv    = inv_r;
    s_top    = top_r;
    s_bottom = bottom_p_r;
    s_base_p = base_p_r;
    s_base_t = base_t_r;
    s_top_t  = top_t_r;
    if (!have_prev_r) begin
      s_bottom = lvl.level_pressure;
    end else if (!stop_r) begin
      if (!inv_r && (prev_p_r < cfg.p_floor)) begin
        s_stop = 1'b1;
      end else if (prev_p_r <= cfg.p_ceiling) begin
        if (!inv_r && (lvl.level_temp > prev_t_r)) begin
          s_base_p = prev_p_r;
          s_base_t = prev_t_r;
          s_inv    = 1'b1;
        end
        if (s_inv && !top_r && (lvl.level_temp < prev_t_r) && (prev_p_r < s_base_p)) begin
          if (prev_rh_r < cfg.rh_limit) begin
            s_top_t = prev_t_r;
            s_top   = 1'b1;
          end else begin
            s_inv = 1'b0;
          end
        end
      end
    end
  end

  assign temp_diff = $signed({2'b00, s_top_t}) - $signed({2'b00, s_base_t});
  assign temp_ok   = !s_top ||
                     (temp_diff >= $signed({{2{cfg.min_rise[T_W-1]}}, cfg.min_rise}));

  always_comb begin
    res_p_nxt    = res_p_r;
    res_corr_nxt = res_corr_r;
    res_oerr_nxt = res_oerr_r;
    res_valid_nxt = res_valid_r && !out_pop;
    if (take && lvl.last_level) begin
      res_valid_nxt = 1'b1;
      res_p_nxt     = lvl.assigned_p;
      res_corr_nxt  = 1'b0;
      res_oerr_nxt  = 1'b0;
      if (lvl.eligible) begin
        if (lvl.level_pressure > s_bottom) begin
          res_oerr_nxt = 1'b1;
        end else if (s_inv && (lvl.assigned_p < s_base_p) && temp_ok) begin
          res_p_nxt    = s_base_p;
          res_corr_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    have_prev_nxt = have_prev_r;
    prev_p_nxt    = prev_p_r;
    prev_t_nxt    = prev_t_r;
    prev_rh_nxt   = prev_rh_r;
    bottom_p_nxt  = bottom_p_r;
    stop_nxt      = stop_r;
    inv_nxt       = inv_r;
    top_nxt       = top_r;
    base_p_nxt    = base_p_r;
    base_t_nxt    = base_t_r;
    top_t_nxt     = top_t_r;
    if (take) begin
      if (lvl.last_level) begin
        have_prev_nxt = 1'b0;
        prev_p_nxt    = '0;
        prev_t_nxt    = '0;
        prev_rh_nxt   = '0;
        bottom_p_nxt  = '0;
        stop_nxt      = 1'b0;
        inv_nxt       = 1'b0;
        top_nxt       = 1'b0;
        base_p_nxt    = BASE_PRESSURE_RST;
        base_t_nxt    = '0;
        top_t_nxt     = '0;
      end else begin
        have_prev_nxt = 1'b1;
        prev_p_nxt    = lvl.level_pressure;
        prev_t_nxt    = lvl.level_temp;
        prev_rh_nxt   = lvl.level_rh;
        bottom_p_nxt  = s_bottom;
        stop_nxt      = s_stop;
        inv_nxt       = s_inv;
        top_nxt       = s_top;
        base_p_nxt    = s_base_p;
        base_t_nxt    = s_base_t;
        top_t_nxt     = s_top_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_p_r    <= '0;
      prev_t_r    <= '0;
      prev_rh_r   <= '0;
      bottom_p_r  <= '0;
      stop_r      <= 1'b0;
      inv_r       <= 1'b0;
      top_r       <= 1'b0;
      base_p_r    <= BASE_PRESSURE_RST;
      base_t_r    <= '0;
      top_t_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
      prev_p_r    <= prev_p_nxt;
      prev_t_r    <= prev_t_nxt;
      prev_rh_r   <= prev_rh_nxt;
      bottom_p_r  <= bottom_p_nxt;
      stop_r      <= stop_nxt;
      inv_r       <= inv_nxt;
      top_r       <= top_nxt;
      base_p_r    <= base_p_nxt;
      base_t_r    <= base_t_nxt;
      top_t_r     <= top_t_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_p_r    <= res_p_nxt;
    res_corr_r <= res_corr_nxt;
    res_oerr_r <= res_oerr_nxt;
  end

endmodule

// ===== rtl/core/amv_inversion_height_correction_top.sv =====
// Top level of the inversion height correction block: configuration registers,
// front end, level queue and back end. Depends on aihc_pkg, aihc_front,
// aihc_queue and aihc_back.
//
//   channel  | handshake              | word
//   ---------+------------------------+-----------------------------------------
//   in_      | in_push / in_full      | one profile level with observation data
//   out_     | out_pop / out_empty    | pressure, corrected and order error bits
//   cfg_     | cfg_we                 | register index and write data
//
// One level a cycle while the queue is not full; a profile ending level is written
// into the queue, then taken by the back end, which registers its result for the
// out_ ports. The scan compares each level only with the previous level's
// registers. Reset is synchronous and clears the queue, the profile state and
// the result. A waiting result stalls only the next profile ending level; the
// queue of four words lets the input side run on meanwhile.
module amv_inversion_height_correction_top
  import aihc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_push,
  output logic              in_full,
  input  logic [P_W-1:0]    in_level_pressure,
  input  logic [T_W-1:0]    in_level_temp,
  input  logic [RH_W-1:0]   in_level_rh,
  input  logic [P_W-1:0]    in_assigned_p,
  input  logic [MC_W-1:0]   in_method_code,
  input  logic              in_apply_obs,
  input  logic              in_last_level,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [P_W-1:0]    out_new_pressure,
  output logic              out_corrected,
  output logic              out_order_error
);

  cfg_t cfg_r, cfg_nxt;
  lvl_t front_lvl, q_head;
  logic q_valid, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_RH_LIMIT:      cfg_nxt.rh_limit      = cfg_wdata[RH_W-1:0];
        REG_P_FLOOR:       cfg_nxt.p_floor       = cfg_wdata[P_W-1:0];
        REG_P_CEILING:     cfg_nxt.p_ceiling     = cfg_wdata[P_W-1:0];
        REG_INV_TEMP:      cfg_nxt.min_rise      = $signed(cfg_wdata[T_W-1:0]);
        REG_INFRARED_CODE: cfg_nxt.infrared_code = cfg_wdata[MC_W-1:0];
        REG_VISIBLE_CODE:  cfg_nxt.visible_code  = cfg_wdata[MC_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rh_limit      <= RH_LIMIT_RST;
      cfg_r.p_floor       <= P_FLOOR_RST;
      cfg_r.p_ceiling     <= P_CEILING_RST;
      cfg_r.min_rise      <= INV_TEMP_RST;
      cfg_r.infrared_code <= INFRARED_CODE_RST;
      cfg_r.visible_code  <= VISIBLE_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  aihc_front u_front (
    .cfg            (cfg_r),
    .level_pressure (in_level_pressure),
    .level_temp     (in_level_temp),
    .level_rh       (in_level_rh),
    .assigned_p     (in_assigned_p),
    .method_code    (in_method_code),
    .apply_obs      (in_apply_obs),
    .last_level     (in_last_level),
    .lvl            (front_lvl)
  );

  aihc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_lvl),
    .full      (in_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  aihc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .lvl_valid        (q_valid),
    .lvl              (q_head),
    .lvl_pop          (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_new_pressure (out_new_pressure),
    .out_corrected    (out_corrected),
    .out_order_error  (out_order_error)
  );

endmodule
